// File: hdl/assert_macros.svh
// assertion macros used by the checker file of the reassembler
// no dependencies; included by files that hold concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define BSR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define BSR_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: hdl/bsr_pkg.sv
// types and constants of the byte stream reassembler
// no dependencies; imported by the cell, the cell row, the top level and the checker
`default_nettype none

package bsr_pkg;

    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 32;
    localparam int END_W     = 33;
    localparam int LEN_W     = 16;
    localparam int RD_W      = 7;
    localparam int CNT_OUT_W = 7;
    localparam int ACT_W     = 2;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 16;

    typedef enum logic [ACT_W-1:0] {
        ACT_STORE   = 2'd0,
        ACT_SEGMENT = 2'd1,
        ACT_READ    = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_FLUSH = 2'b10
    } t_state;

    // control from the sequencer to the row of cells
    typedef struct packed {
        logic              shift;
        logic              wr_en;
        logic [BYTE_W-1:0] wr_byte;
    } t_row_ctrl;

    // status from the row of cells to the sequencer
    typedef struct packed {
        logic              head_valid;
        logic              second_valid;
        logic              new_mark;
        logic [BYTE_W-1:0] head_byte;
    } t_row_stat;

endpackage

`default_nettype wire

// File: hdl/bsr_cell.sv
// one window cell: a valid mark and a stored byte, shifting toward the head
// uses bsr_pkg for the byte width
`default_nettype none

module bsr_cell
    import bsr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_shift,
    input  wire logic              i_wr,
    input  wire logic [BYTE_W-1:0] i_wr_byte,
    input  wire logic              i_nbr_valid,
    input  wire logic [BYTE_W-1:0] i_nbr_byte,
    output logic                   o_valid,
    output logic [BYTE_W-1:0]      o_byte,
    output logic                   o_new_mark
);

    logic              r_valid;
    logic              n_valid;
    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] n_byte;

    always_comb begin
        n_valid = r_valid;
        n_byte  = r_byte;
        if (i_shift) begin
            n_valid = i_nbr_valid;
            n_byte  = i_nbr_byte;
        end else if (i_wr) begin
            // a repeated byte overwrites the old value
            n_valid = 1'b1;
            n_byte  = i_wr_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_valid    = r_valid;
    assign o_byte     = r_byte;
    assign o_new_mark = i_wr && !r_valid;

endmodule

`default_nettype wire

// File: hdl/bsr_cell_row.sv
// row of window cells; cell k holds the byte at next index plus k
// uses bsr_pkg and bsr_cell
`default_nettype none

module bsr_cell_row
    import bsr_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_row_ctrl                   i_ctrl,
    input  wire logic [$clog2(CAPACITY)-1:0] i_wr_off,
    output t_row_stat                        o_stat
);

    localparam int OW = $clog2(CAPACITY);

    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_new;
    logic [BYTE_W-1:0]   w_byte [CAPACITY];

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic              w_nbr_valid;
        logic [BYTE_W-1:0] w_nbr_byte;
        logic              w_sel;

        if (k == CAPACITY - 1) begin : g_tail
            // an empty slot enters at the far end of the window
            assign w_nbr_valid = 1'b0;
            assign w_nbr_byte  = '0;
        end else begin : g_body
            assign w_nbr_valid = w_valid[k+1];
            assign w_nbr_byte  = w_byte[k+1];
        end

        assign w_sel = i_ctrl.wr_en && (i_wr_off == OW'(k));

        bsr_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_shift     (i_ctrl.shift),
            .i_wr        (w_sel),
            .i_wr_byte   (i_ctrl.wr_byte),
            .i_nbr_valid (w_nbr_valid),
            .i_nbr_byte  (w_nbr_byte),
            .o_valid     (w_valid[k]),
            .o_byte      (w_byte[k]),
            .o_new_mark  (w_new[k])
        );
    end

    assign o_stat.head_valid   = w_valid[0];
    assign o_stat.second_valid = w_valid[1];
    assign o_stat.new_mark     = |w_new;
    assign o_stat.head_byte    = w_byte[0];

endmodule

`default_nettype wire

// File: hdl/byte_stream_reassembler.sv
// top level of the byte stream reassembler: sequencer, counters, output register
// uses bsr_pkg and bsr_cell_row
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid / s_axis_tready  tdata, tuser = action, tlast = eof_flag
//  m_axis   out  m_axis_tvalid / m_axis_tready  tdata, tuser = has_byte, tlast = last
//
// store, read and unused items and a segment item starting past the window are
// done when accepted; any other segment item then delivers its bytes, or its lone
// status result, at one byte per cycle through the row while the output is not stalled
// reset is synchronous, active low, and empties the window at once
// input waits while a delivery runs or the output register holds a stalled result
`default_nettype none

module byte_stream_reassembler
    import bsr_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // data_byte[7:0], stream_index[39:8], segment_length[55:40],
    // read_count[62:56], zero[63]
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // action[1:0]
    input  wire logic [ACT_W-1:0]     s_axis_tuser,
    input  wire logic                 s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // out_byte[7:0], end_of_stream[8], unassembled_count[15:9]
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    // has_byte[0]
    output logic                      m_axis_tuser,
    output logic                      m_axis_tlast
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int OW = $clog2(CAPACITY);

    t_action           w_action;
    logic [BYTE_W-1:0] w_in_byte;
    logic [IDX_W-1:0]  w_in_index;
    logic [LEN_W-1:0]  w_in_len;
    logic [RD_W-1:0]   w_in_read;
    logic              w_in_eof;

    assign w_action   = t_action'(s_axis_tuser);
    assign w_in_byte  = s_axis_tdata[7:0];
    assign w_in_index = s_axis_tdata[39:8];
    assign w_in_len   = s_axis_tdata[55:40];
    assign w_in_read  = s_axis_tdata[62:56];
    assign w_in_eof   = s_axis_tlast;

    t_state             r_state;
    t_state             n_state;
    logic [IDX_W-1:0]   r_next;
    logic [IDX_W-1:0]   n_next;
    logic [END_W-1:0]   r_end;
    logic [END_W-1:0]   n_end;
    logic               r_end_known;
    logic               n_end_known;
    logic [CW-1:0]      r_fill;
    logic [CW-1:0]      n_fill;
    logic [CW-1:0]      r_pending;
    logic [CW-1:0]      n_pending;

    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 r_out_has;
    logic                 n_out_has;
    logic [BYTE_W-1:0]    r_out_byte;
    logic [BYTE_W-1:0]    n_out_byte;
    logic                 r_out_last;
    logic                 n_out_last;
    logic                 r_out_eos;
    logic                 n_out_eos;
    logic [CNT_OUT_W-1:0] r_out_unasm;
    logic [CNT_OUT_W-1:0] n_out_unasm;

    t_row_ctrl w_ctrl;
    t_row_stat w_stat;

    logic             w_out_free;
    logic             w_in_acc;
    logic [END_W-1:0] w_limit;
    logic [IDX_W-1:0] w_off;
    logic             w_in_win;
    logic             w_start_ok;
    logic [END_W-1:0] w_seg_end;
    logic             w_fit;
    logic             w_at_end;
    logic [IDX_W-1:0] w_next_plus;
    logic             w_at_end_after;
    logic             w_go;
    logic             w_go_more;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // window tests run on 33 bits and do not wrap
    assign w_limit    = {1'b0, r_next} + END_W'(CAPACITY);
    assign w_off      = w_in_index - r_next;
    assign w_in_win   = (w_in_index >= r_next) && (w_off < IDX_W'(CAPACITY));
    assign w_start_ok = {1'b0, w_in_index} <= w_limit;
    assign w_seg_end  = {1'b0, w_in_index} + END_W'(w_in_len);
    assign w_fit      = w_in_eof && (w_seg_end <= w_limit);

    assign w_at_end       = r_end_known && ({1'b0, r_next} == r_end);
    assign w_next_plus    = r_next + IDX_W'(1);
    assign w_at_end_after = r_end_known && ({1'b0, w_next_plus} == r_end);

    assign w_go      = (r_fill < CW'(CAPACITY)) && !w_at_end && w_stat.head_valid;
    assign w_go_more = (r_fill < CW'(CAPACITY - 1)) && !w_at_end_after
                       && w_stat.second_valid;

    always_comb begin
        n_state      = r_state;
        n_next       = r_next;
        n_end        = r_end;
        n_end_known  = r_end_known;
        n_fill       = r_fill;
        n_pending    = r_pending;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_has    = r_out_has;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_out_eos    = r_out_eos;
        n_out_unasm  = r_out_unasm;
        w_ctrl.shift   = 1'b0;
        w_ctrl.wr_en   = 1'b0;
        w_ctrl.wr_byte = w_in_byte;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    unique case (w_action)
                        ACT_STORE: begin
                            w_ctrl.wr_en = w_in_win;
                            if (w_stat.new_mark) begin
                                n_pending = r_pending + CW'(1);
                            end
                        end
                        ACT_SEGMENT: begin
                            if (w_start_ok) begin
                                if (w_fit) begin
                                    n_end       = w_seg_end;
                                    n_end_known = 1'b1;
                                end
                                n_state = ST_FLUSH;
                            end else begin
                                n_out_valid = 1'b1;
                                n_out_has   = 1'b0;
                                n_out_byte  = '0;
                                n_out_last  = 1'b1;
                                n_out_eos   = w_at_end;
                                n_out_unasm = CNT_OUT_W'(r_pending);
                            end
                        end
                        ACT_READ: begin
                            if (w_in_read >= RD_W'(r_fill)) begin
                                n_fill = '0;
                            end else begin
                                n_fill = CW'(RD_W'(r_fill) - w_in_read);
                            end
                            n_out_valid = 1'b1;
                            n_out_has   = 1'b0;
                            n_out_byte  = '0;
                            n_out_last  = 1'b1;
                            n_out_eos   = w_at_end;
                            n_out_unasm = CNT_OUT_W'(r_pending);
                        end
                        ACT_NONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FLUSH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (w_go) begin
                        // status rides on the final byte, taken after this step
                        w_ctrl.shift = 1'b1;
                        n_next       = w_next_plus;
                        n_fill       = r_fill + CW'(1);
                        n_pending    = r_pending - CW'(1);
                        n_out_has    = 1'b1;
                        n_out_byte   = w_stat.head_byte;
                        n_out_last   = !w_go_more;
                        n_out_eos    = !w_go_more && w_at_end_after;
                        n_out_unasm  = w_go_more ? '0 : CNT_OUT_W'(r_pending - CW'(1));
                        if (!w_go_more) begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        // nothing deliverable for this segment: lone status
                        n_out_has   = 1'b0;
                        n_out_byte  = '0;
                        n_out_last  = 1'b1;
                        n_out_eos   = w_at_end;
                        n_out_unasm = CNT_OUT_W'(r_pending);
                        n_state     = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_next      <= '0;
            r_end       <= '0;
            r_end_known <= 1'b0;
            r_fill      <= '0;
            r_pending   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next      <= n_next;
            r_end       <= n_end;
            r_end_known <= n_end_known;
            r_fill      <= n_fill;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_has   <= n_out_has;
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
        r_out_eos   <= n_out_eos;
        r_out_unasm <= n_out_unasm;
    end

    bsr_cell_row #(
        .CAPACITY (CAPACITY)
    ) u_row (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_wr_off (w_off[OW-1:0]),
        .o_stat   (w_stat)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_unasm, r_out_eos, r_out_byte};
    assign m_axis_tuser  = r_out_has;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// File: hdl/bsr_checker.sv
// port level checks of the byte stream reassembler, bound to the top level
// uses bsr_pkg for port widths and assert_macros.svh for the assertion form
`default_nettype none

`include "assert_macros.svh"

module bsr_checker
    import bsr_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic [S_TDATA_W-1:0] s_axis_tdata,
    input wire logic [ACT_W-1:0]     s_axis_tuser,
    input wire logic                 s_axis_tlast,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                 m_axis_tuser,
    input wire logic                 m_axis_tlast
);

    // a result without a byte is always the closing status
    `BSR_ASSERT(a_status_is_last, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast, "status result without tlast")

    // no input transaction while a delivery run is still open
    `BSR_ASSERT(a_no_input_mid_run, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready, "input taken in the middle of a delivery run")

    // status fields stay zero on bytes before the last one
    `BSR_ASSERT_NEVER(a_clean_mid_run, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast && (m_axis_tdata[15:8] != 8'd0), "status fields set on a non-final result")

    // a stalled result holds
    `BSR_ASSERT(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser)), "stalled result changed")

endmodule

bind byte_stream_reassembler bsr_checker u_bsr_checker (.*);

`default_nettype wire
